// ===== design/tadl_pkg.sv =====
// ----------------------------------------------------------------------------
// tadl_pkg: shared types and constants for the base-3 discrete log pipeline
// Field widths, status codes, the stage payload and the table of
// log3(1 + 2^k) mod 2^62 used by the bit elimination stages.
// ----------------------------------------------------------------------------
package tadl_pkg;

  // field widths
  localparam int VALUE_W  = 30;
  localparam int EXP_W    = 62;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 3;

  // magnitude limit of an accepted candidate
  localparam int MAG_BITS = 29;
  localparam logic [WORD_W-1:0] MAG_LIMIT = WORD_W'(1) << MAG_BITS;

  // first bit cleared by a stage, and the number of stages
  localparam int FIRST_BIT = 3;
  localparam int NUM_STEPS = WORD_W - FIRST_BIT;

  // reset value of the exponent bound
  localparam logic [EXP_W-1:0] BOUND_RESET = 62'd42150931629;

  // residues mod 8 that lie in the subgroup generated by 3
  localparam logic [2:0] RES_ONE   = 3'd1;
  localparam logic [2:0] RES_THREE = 3'd3;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT        = 3'd0,
    ST_EXCLUDED   = 3'd1,
    ST_OVER_BOUND = 3'd2,
    ST_TRIVIAL    = 3'd3,
    ST_MISMATCH   = 3'd4
  } tadl_status_e;

  // payload carried from stage to stage
  typedef struct packed {
    logic               excl;
    logic [WORD_W-1:0]  x;
    logic [EXP_W-1:0]   acc;
    logic [VALUE_W-1:0] value;
  } tadl_data_t;

  typedef logic [NUM_STEPS-1:0][EXP_W-1:0] tadl_tab_t;

  // bitwise base-3 log of a residue of 1 or 3 mod 8, elaboration only
  function automatic logic [EXP_W-1:0] dlog3(input logic [WORD_W-1:0] u);
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] g;
    logic [WORD_W-1:0] mask;
    logic [EXP_W-1:0]  a;
    a = (u[2:0] == RES_THREE) ? EXP_W'(1) : EXP_W'(0);
    p = (u[2:0] == RES_THREE) ? WORD_W'(3) : WORD_W'(1);
    g = WORD_W'(3);
    for (int j = 1; j < EXP_W; j++) begin
      g = g * g;
      mask = (j == EXP_W - 1) ? {WORD_W{1'b1}} : ((WORD_W'(1) << (j + 3)) - WORD_W'(1));
      if (((p ^ u) & mask) != '0) begin
        a = a | (EXP_W'(1) << j);
        p = p * g;
      end
    end
    return a;
  endfunction

  // log3(1 + 2^k) for every stage bit k
  function automatic tadl_tab_t build_tab();
    tadl_tab_t t;
    for (int k = 0; k < NUM_STEPS; k++) begin
      t[k] = dlog3(WORD_W'(1) | (WORD_W'(1) << (k + FIRST_BIT)));
    end
    return t;
  endfunction

  localparam tadl_tab_t DLOG_TAB = build_tab();

endpackage

// ===== design/tadl_front.sv =====
// ----------------------------------------------------------------------------
// tadl_front: input stage
// Screens the candidate, sign-extends it to 64 bits and folds a residue of
// 3 mod 8 onto 1 mod 8 by a multiply by 3, seeding the exponent with one.
// ----------------------------------------------------------------------------
module tadl_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [tadl_pkg::VALUE_W-1:0]  value_i,
  output logic                                 valid_o,
  output tadl_pkg::tadl_data_t                 data_o
);

  logic [tadl_pkg::VALUE_W-1:0] value_u;
  logic [tadl_pkg::VALUE_W-1:0] mag;
  logic [tadl_pkg::WORD_W-1:0]  x_ext;
  logic                         res_ok;
  logic                         too_big;
  logic                         valid_q;
  tadl_pkg::tadl_data_t         data_d;
  tadl_pkg::tadl_data_t         data_q;

  // screening and fold onto 1 mod 8
  always_comb begin
    value_u = $unsigned(value_i);
    mag     = value_u[tadl_pkg::VALUE_W-1] ? (~value_u + tadl_pkg::VALUE_W'(1)) : value_u;
    too_big = {{(tadl_pkg::WORD_W - tadl_pkg::VALUE_W){1'b0}}, mag} >= tadl_pkg::MAG_LIMIT;
    res_ok  = value_u[2:0] inside {tadl_pkg::RES_ONE, tadl_pkg::RES_THREE};
    x_ext   = {{(tadl_pkg::WORD_W - tadl_pkg::VALUE_W){value_u[tadl_pkg::VALUE_W-1]}}, value_u};

    data_d.excl  = too_big || !res_ok;
    data_d.value = value_u;
    if (value_u[2:0] == tadl_pkg::RES_THREE) begin
      data_d.x   = x_ext + (x_ext << 1);
      data_d.acc = tadl_pkg::EXP_W'(1);
    end else begin
      data_d.x   = x_ext;
      data_d.acc = '0;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/tadl_step.sv =====
// ----------------------------------------------------------------------------
// tadl_step: one bit elimination stage
// Clears bit BIT_POS of the running residue by a multiply by (1 + 2^BIT_POS),
// a shift and add, and adds that factor's base-3 log to the exponent.
// ----------------------------------------------------------------------------
module tadl_step #(
  parameter int BIT_POS = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tadl_pkg::tadl_data_t data_i,
  output logic                 valid_o,
  output tadl_pkg::tadl_data_t data_o
);

  localparam int TAB_IDX = BIT_POS - tadl_pkg::FIRST_BIT;

  logic                 sel;
  logic                 valid_q;
  tadl_pkg::tadl_data_t data_d;
  tadl_pkg::tadl_data_t data_q;

  // conditional multiply by (1 + 2^k) and log accumulation
  always_comb begin
    sel    = data_i.x[BIT_POS];
    data_d = data_i;
    if (sel) begin
      data_d.x   = data_i.x + (data_i.x << BIT_POS);
      data_d.acc = data_i.acc + tadl_pkg::DLOG_TAB[TAB_IDX];
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/tadl_back.sv =====
// ----------------------------------------------------------------------------
// tadl_back: result stage
// Checks the residue came down to one, classifies the exponent against the
// bound and registers the result with its strobe.
// ----------------------------------------------------------------------------
module tadl_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  tadl_pkg::tadl_data_t                 data_i,
  input  logic [tadl_pkg::EXP_W-1:0]           bound_i,
  output logic                                 done_o,
  output logic [tadl_pkg::STATUS_W-1:0]        status_o,
  output logic [tadl_pkg::EXP_W-1:0]           exponent_o,
  output logic signed [tadl_pkg::VALUE_W-1:0]  value_echo_o
);

  tadl_pkg::tadl_status_e       status_d;
  tadl_pkg::tadl_status_e       status_q;
  logic [tadl_pkg::EXP_W-1:0]   exponent_d;
  logic [tadl_pkg::EXP_W-1:0]   exponent_q;
  logic [tadl_pkg::VALUE_W-1:0] value_q;
  logic                         done_q;

  // status decode; bit zero alone is never checked against the bound
  always_comb begin
    if (data_i.excl) begin
      status_d = tadl_pkg::ST_EXCLUDED;
    end else if (data_i.acc == '0) begin
      status_d = tadl_pkg::ST_TRIVIAL;
    end else if ((data_i.acc > bound_i) && (data_i.acc[tadl_pkg::EXP_W-1:1] != '0)) begin
      status_d = tadl_pkg::ST_OVER_BOUND;
    end else if (data_i.x != tadl_pkg::WORD_W'(1)) begin
      status_d = tadl_pkg::ST_MISMATCH;
    end else begin
      status_d = tadl_pkg::ST_HIT;
    end
    exponent_d = (status_d == tadl_pkg::ST_HIT) ? data_i.acc : '0;
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    exponent_q <= exponent_d;
    value_q    <= data_i.value;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign exponent_o   = exponent_q;
  assign value_echo_o = $signed(value_q);

endmodule

// ===== design/two_adic_discrete_log_base3.sv =====
// ----------------------------------------------------------------------------
// two_adic_discrete_log_base3: base-3 discrete log of 1/m modulo 2^64
// Takes a signed candidate m and returns the exponent a with 3^a = 1/m.
// ----------------------------------------------------------------------------
// An item is taken at every clock edge with start high; busy never rises, so
// one item enters per cycle. Each item passes in order through one input stage,
// 61 elimination stages (one 64-bit shift and add per bit of the residue, bits
// 3 to 63) and one result stage, each a register. The result is shown for a
// single cycle with done_o high and cannot be held off, so the receiver must
// take it then. Results leave in the order items came in.
// The exponent bound may only be written while no item is in flight.
module two_adic_discrete_log_base3 (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tadl_pkg::VALUE_W-1:0]  value_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tadl_pkg::EXP_W-1:0]           cfg_data_i,
  output logic                                 done_o,
  output logic [tadl_pkg::STATUS_W-1:0]        status_o,
  output logic [tadl_pkg::EXP_W-1:0]           exponent_o,
  output logic signed [tadl_pkg::VALUE_W-1:0]  value_echo_o
);

  logic [tadl_pkg::EXP_W-1:0]   bound_q;
  logic [tadl_pkg::EXP_W-1:0]   bound_d;
  logic                         in_take;
  logic [tadl_pkg::NUM_STEPS:0] stg_valid;
  tadl_pkg::tadl_data_t         stg_data [tadl_pkg::NUM_STEPS+1];

  // handshakes
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_take     = start && !busy;

  // exponent bound register
  assign bound_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : bound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= tadl_pkg::BOUND_RESET;
    end else begin
      bound_q <= bound_d;
    end
  end

  // input stage
  tadl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_take),
    .value_i (value_i),
    .valid_o (stg_valid[0]),
    .data_o  (stg_data[0])
  );

  // bit elimination stages
  for (genvar g = 0; g < tadl_pkg::NUM_STEPS; g++) begin : g_step
    tadl_step #(
      .BIT_POS (g + tadl_pkg::FIRST_BIT)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  // result stage
  tadl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (stg_valid[tadl_pkg::NUM_STEPS]),
    .data_i       (stg_data[tadl_pkg::NUM_STEPS]),
    .bound_i      (bound_q),
    .done_o       (done_o),
    .status_o     (status_o),
    .exponent_o   (exponent_o),
    .value_echo_o (value_echo_o)
  );

endmodule
